// ===== design/sht_pkg.sv =====
// Package for the symbol hash table: sizes, codes, payload and control types.
// Used by the channel interfaces and by every module of the block.
package sht_pkg;

   localparam int TABLE_SLOTS   = 1024;
   localparam int MAX_OVERLOADS = 16;
   localparam int SLOT_W        = $clog2(TABLE_SLOTS);
   localparam int OVL_W         = $clog2(MAX_OVERLOADS);
   localparam int CNT_W         = $clog2(MAX_OVERLOADS + 1);
   localparam int OCC_W         = $clog2(TABLE_SLOTS + 1);
   localparam int DECL_W        = SLOT_W + OVL_W;
   // Smallest occupancy at which occupancy*4 >= slots*3.
   localparam int LOAD_LIMIT    = (TABLE_SLOTS * 3 + 3) / 4;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED   = 3'd0,
      ST_OVL_ADDED  = 3'd1,
      ST_DUPLICATE  = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_OVL_FULL   = 3'd4,
      ST_FOUND      = 3'd5,
      ST_NOT_FOUND  = 3'd6,
      ST_BAD_KEY    = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_DECL
   } state_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] key_hash;
      logic [3:0]  symbol_kind;
      logic [31:0] file_handle;
      logic [31:0] declaration_handle;
      logic [3:0]  overload_select;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [9:0]  slot_index;
      logic [3:0]  found_kind;
      logic [31:0] found_file;
      logic [31:0] found_declaration;
      logic [4:0]  overload_total;
   } rsp_payload_type;

   typedef struct packed {
      req_payload_type payload;
      logic            bad_key;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type item;
   } queue_head_type;

endpackage

// ===== design/sht_req_if.sv =====
// Request channel interface: valid, ready and one request payload.
// Depends on sht_pkg for the payload type.
interface sht_req_if import sht_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sht_rsp_if.sv =====
// Response channel interface: valid, ready and one result payload.
// Depends on sht_pkg for the payload type.
interface sht_rsp_if import sht_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sht_front.sv =====
// Front end: accepts request beats, flags bad keys and queues them in a
// two-entry queue for the back end. Depends on sht_pkg and sht_req_if.
module sht_front import sht_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   sht_req_if.sink        req_bus,
   output queue_head_type head,
   input  logic           pop
);

   work_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   work_type   new_item;

   assign req_bus.ready = (cnt_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      new_item.payload = req_bus.payload;
      new_item.bad_key = (req_bus.payload.key_hash == 32'd0);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== design/sht_back.sv =====
// Back end: probe sequencer over the slot and declaration memories, and the
// response register. Depends on sht_pkg and sht_rsp_if.
module sht_back import sht_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   input  logic [3:0]     fsk,
   sht_rsp_if.source      rsp_bus
);

   logic [31:0]      key_mem  [TABLE_SLOTS];
   logic [3:0]       kind_mem [TABLE_SLOTS];
   logic [31:0]      file_mem [TABLE_SLOTS];
   logic [CNT_W-1:0] cnt_mem  [TABLE_SLOTS];
   logic [31:0]      decl_mem [TABLE_SLOTS * MAX_OVERLOADS];

   state_type        state_ff, state_in;
   work_type         work_ff, work_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] n_ff, n_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             zero_ff, zero_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [31:0]      key_rd_ff;
   logic [3:0]       kind_rd_ff;
   logic [31:0]      file_rd_ff;
   logic [CNT_W-1:0] cnt_rd_ff;
   logic [31:0]      decl_rd_ff;

   logic             slot_we;
   logic [SLOT_W-1:0] slot_addr;
   logic [31:0]      slot_key_wd;
   logic [31:0]      slot_file_wd;
   logic [CNT_W-1:0] slot_cnt_wd;
   logic             decl_we;
   logic [DECL_W-1:0] decl_addr;
   logic             rsp_load;

   logic key_empty, hit, last, is_lookup, fs_stored, fs_new, load_full, start;

   assign key_empty = (key_rd_ff == 32'd0);
   assign hit       = key_empty || (key_rd_ff == work_ff.payload.key_hash);
   assign last      = (n_ff == SLOT_W'(TABLE_SLOTS - 1));
   assign is_lookup = (work_ff.payload.req_type == REQ_LOOKUP);
   assign fs_stored = (kind_rd_ff == fsk);
   assign fs_new    = (work_ff.payload.symbol_kind == fsk);
   assign load_full = (occ_ff >= OCC_W'(LOAD_LIMIT));
   assign start     = head.valid && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == SLOT_W'(TABLE_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start && !head.item.bad_key) state_in = S_READ;
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (!hit) begin
               state_in = last ? S_IDLE : S_READ;
            end else if (is_lookup && !key_empty) begin
               state_in = S_DECL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DECL: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      work_in      = work_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      clr_in       = clr_ff;
      occ_in       = occ_ff;
      zero_in      = zero_ff;
      slot_we      = 1'b0;
      slot_addr    = idx_ff;
      slot_key_wd  = work_ff.payload.key_hash;
      slot_file_wd = work_ff.payload.file_handle;
      slot_cnt_wd  = fs_new ? CNT_W'(1) : CNT_W'(0);
      decl_we      = 1'b0;
      decl_addr    = {idx_ff, OVL_W'(0)};
      rsp_load     = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            slot_we     = 1'b1;
            slot_addr   = clr_ff;
            slot_key_wd = 32'd0;
            clr_in      = clr_ff + SLOT_W'(1);
         end
         S_IDLE: begin
            if (start) begin
               pop     = 1'b1;
               work_in = head.item;
               idx_in  = head.item.payload.key_hash[SLOT_W-1:0];
               n_in    = '0;
               if (head.item.bad_key) begin
                  rsp_load      = 1'b1;
                  rsp_in.status = ST_BAD_KEY;
               end
            end
         end
         S_READ: ;
         S_CHECK: begin
            if (!hit) begin
               idx_in = idx_ff + SLOT_W'(1);
               n_in   = n_ff + SLOT_W'(1);
               if (last) begin
                  rsp_load      = 1'b1;
                  rsp_in.status = is_lookup ? ST_NOT_FOUND : ST_TABLE_FULL;
               end
            end else if (is_lookup) begin
               if (key_empty) begin
                  rsp_load      = 1'b1;
                  rsp_in.status = ST_NOT_FOUND;
               end else begin
                  // Function sets pick an overload; plain symbols use entry 0.
                  decl_addr = {idx_ff, fs_stored ? work_ff.payload.overload_select[OVL_W-1:0]
                                                 : OVL_W'(0)};
                  zero_in   = fs_stored &&
                              (CNT_W'(work_ff.payload.overload_select) >= cnt_rd_ff);
               end
            end else if (key_empty) begin
               rsp_load = 1'b1;
               if (load_full) begin
                  rsp_in.status = ST_TABLE_FULL;
               end else begin
                  slot_we               = 1'b1;
                  decl_we               = 1'b1;
                  occ_in                = occ_ff + OCC_W'(1);
                  rsp_in.status         = ST_INSERTED;
                  rsp_in.slot_index     = 10'(idx_ff);
                  rsp_in.overload_total = 5'(slot_cnt_wd);
               end
            end else begin
               rsp_load              = 1'b1;
               rsp_in.slot_index     = 10'(idx_ff);
               rsp_in.overload_total = 5'(cnt_rd_ff);
               if (!fs_stored || !fs_new) begin
                  rsp_in.status = ST_DUPLICATE;
               end else if (cnt_rd_ff >= CNT_W'(MAX_OVERLOADS)) begin
                  rsp_in.status = ST_OVL_FULL;
               end else begin
                  // Append one overload; key and kind are rewritten unchanged and
                  // the stored file handle is carried over from the slot read.
                  slot_we               = 1'b1;
                  slot_file_wd          = file_rd_ff;
                  slot_cnt_wd           = cnt_rd_ff + CNT_W'(1);
                  decl_we               = 1'b1;
                  decl_addr             = {idx_ff, cnt_rd_ff[OVL_W-1:0]};
                  rsp_in.status         = ST_OVL_ADDED;
                  rsp_in.overload_total = 5'(cnt_rd_ff + CNT_W'(1));
               end
            end
         end
         S_DECL: begin
            rsp_load                 = 1'b1;
            rsp_in.status            = ST_FOUND;
            rsp_in.slot_index        = 10'(idx_ff);
            rsp_in.found_kind        = kind_rd_ff;
            rsp_in.found_file        = file_rd_ff;
            rsp_in.found_declaration = zero_ff ? 32'd0 : decl_rd_ff;
            rsp_in.overload_total    = 5'(cnt_rd_ff);
         end
         default: ;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      idx_ff  <= idx_in;
      n_ff    <= n_in;
      zero_ff <= zero_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         key_mem[slot_addr]  <= slot_key_wd;
         kind_mem[slot_addr] <= work_ff.payload.symbol_kind;
         file_mem[slot_addr] <= slot_file_wd;
         cnt_mem[slot_addr]  <= slot_cnt_wd;
      end
      key_rd_ff  <= key_mem[idx_ff];
      kind_rd_ff <= kind_mem[idx_ff];
      file_rd_ff <= file_mem[idx_ff];
      cnt_rd_ff  <= cnt_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (decl_we) begin
         decl_mem[decl_addr] <= work_ff.payload.declaration_handle;
      end
      decl_rd_ff <= decl_mem[decl_addr];
   end

`ifndef SYNTHESIS
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !pop)
      else $error("request taken during the clearing pass");
   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(LOAD_LIMIT))
      else $error("occupancy above the load limit");
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff)
      else $error("result overwrote a pending response");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (pop && !head.item.bad_key) |=> !rsp_load)
      else $error("result issued before the first probe");
`endif

endmodule

// ===== design/symbol_hash_table.sv =====
// Symbol hash table: an open-addressed table of 1024 slots with linear probing,
// keyed by a 32-bit hash, holding up to 16 overload declarations per function set.
// After reset the block clears the key memory; up to two request beats are queued
// meanwhile and are served once that pass is done. The configuration register can
// be written at any time while the block is idle. Requests are queued two deep by
// the front end, so the request side keeps moving until both entries are full while
// a result waits to be taken. The back end handles one request at a time: each
// probed slot takes a registered read of the slot memories (S_READ), then the
// compare (S_CHECK); an insert or a failed lookup finishes in the compare state,
// and a successful lookup adds the S_DECL state for the declaration memory read. A
// bad key (hash zero) is answered in the cycle after it is taken from the queue.
// The response register holds a result until its beat is taken, and the next
// request starts only once it is free.
module symbol_hash_table import sht_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sht_req_if.sink    req_bus,
   sht_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data
);

   logic [3:0]     fsk_ff, fsk_in;
   queue_head_type head;
   logic           pop;

   // Kind code that marks an overloadable function set.
   assign fsk_in = csr_write_enable ? csr_write_data : fsk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsk_ff <= 4'd0;
      end else begin
         fsk_ff <= fsk_in;
      end
   end

   sht_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .head    (head),
      .pop     (pop)
   );

   sht_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .fsk     (fsk_ff),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== tb/sht_checker.sv =====
// Checker for the symbol hash table: watches the request and response channels,
// keeps its own copy of the table and compares every response beat.
// Depends on sht_pkg only; it takes the channel signals as plain ports.
module sht_checker import sht_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [3:0]      csr_write_data,
   output int              error_count,
   output int              pending_count,
   output int              response_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] key_mem [TABLE_SLOTS];
   logic [3:0]  kind_mem [TABLE_SLOTS];
   logic [31:0] file_mem [TABLE_SLOTS];
   logic [4:0]  count_mem [TABLE_SLOTS];
   logic [31:0] decl_mem [TABLE_SLOTS * MAX_OVERLOADS];
   int          occupancy;
   logic [3:0]  fn_set_kind;
   rsp_payload_type expected_rsps [$];

   function automatic rsp_payload_type blank_rsp(status_type st);
      rsp_payload_type r;
      r = '0;
      r.status = st;
      return r;
   endfunction

   // Applies one request to the local table and returns the response it earns.
   function automatic rsp_payload_type table_access(req_payload_type q);
      rsp_payload_type r;
      int unsigned     pos;
      int unsigned     base;
      int unsigned     n;
      bit              hit;
      logic [4:0]      cnt;
      r = '0;
      hit = 0;
      if (q.key_hash == 0) return blank_rsp(ST_BAD_KEY);
      pos = q.key_hash % TABLE_SLOTS;
      for (n = 0; n < TABLE_SLOTS; n++) begin
         if (key_mem[pos] == 0 || key_mem[pos] == q.key_hash) begin
            hit = 1;
            break;
         end
         pos = (pos + 1) % TABLE_SLOTS;
      end
      base = pos * MAX_OVERLOADS;
      if (q.req_type == REQ_LOOKUP) begin
         if (!hit || key_mem[pos] == 0) return blank_rsp(ST_NOT_FOUND);
         cnt = count_mem[pos];
         r.status = ST_FOUND;
         r.slot_index = 10'(pos);
         r.found_kind = kind_mem[pos];
         r.found_file = file_mem[pos];
         r.overload_total = cnt;
         if (kind_mem[pos] == fn_set_kind)
            r.found_declaration = (q.overload_select < cnt) ?
                                  decl_mem[base + q.overload_select] : '0;
         else
            r.found_declaration = decl_mem[base];
         return r;
      end
      if (!hit) return blank_rsp(ST_TABLE_FULL);
      if (key_mem[pos] == 0) begin
         if (occupancy * 4 >= TABLE_SLOTS * 3) return blank_rsp(ST_TABLE_FULL);
         key_mem[pos] = q.key_hash;
         kind_mem[pos] = q.symbol_kind;
         file_mem[pos] = q.file_handle;
         decl_mem[base] = q.declaration_handle;
         count_mem[pos] = (q.symbol_kind == fn_set_kind) ? 5'd1 : 5'd0;
         occupancy++;
         r.status = ST_INSERTED;
         r.slot_index = 10'(pos);
         r.overload_total = count_mem[pos];
         return r;
      end
      cnt = count_mem[pos];
      r.slot_index = 10'(pos);
      r.overload_total = cnt;
      if (kind_mem[pos] != fn_set_kind || q.symbol_kind != fn_set_kind)
         r.status = ST_DUPLICATE;
      else if (cnt >= MAX_OVERLOADS)
         r.status = ST_OVL_FULL;
      else begin
         decl_mem[base + cnt] = q.declaration_handle;
         count_mem[pos] = cnt + 5'd1;
         r.status = ST_OVL_ADDED;
         r.overload_total = cnt + 5'd1;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      response_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         foreach (key_mem[i]) key_mem[i] = '0;
         occupancy = 0;
         fn_set_kind = '0;
      end else begin
         if (csr_write_enable) fn_set_kind = csr_write_data;
         if (req_valid && req_ready) expected_rsps.push_back(table_access(req_payload));
         if (rsp_valid && rsp_ready) begin
            response_count++;
            if (expected_rsps.size() == 0)
               report_mismatch("unexpected beat, status", rsp_payload.status, 0);
            else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.status != want.status)
                  report_mismatch("status", rsp_payload.status, want.status);
               if (rsp_payload.slot_index != want.slot_index)
                  report_mismatch("slot_index", rsp_payload.slot_index, want.slot_index);
               if (rsp_payload.found_kind != want.found_kind)
                  report_mismatch("found_kind", rsp_payload.found_kind, want.found_kind);
               if (rsp_payload.found_file != want.found_file)
                  report_mismatch("found_file", rsp_payload.found_file, want.found_file);
               if (rsp_payload.found_declaration != want.found_declaration)
                  report_mismatch("found_declaration", rsp_payload.found_declaration,
                                  want.found_declaration);
               if (rsp_payload.overload_total != want.overload_total)
                  report_mismatch("overload_total", rsp_payload.overload_total,
                                  want.overload_total);
            end
         end
         pending_count = expected_rsps.size();
      end
   end

   task automatic report_leftovers();
      if (expected_rsps.size() != 0)
         report_mismatch("responses never delivered", expected_rsps.size(), 0);
   endtask
endmodule

// ===== tb/tb_symbol_hash_table.sv =====
// Top of the symbol hash table testbench: clock, reset, stimulus and verdict.
// Depends on sht_pkg, the channel interfaces, sht_checker and the block itself.
module tb_symbol_hash_table import sht_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 900000;

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_write_enable = 0;
   logic [3:0] csr_write_data = '0;
   int         cycle_count = 0;
   int         error_count;
   int         pending_count;
   int         response_count;
   int         beats_sent = 0;
   int         rsp_gap = 0;
   bit         sink_stall_long = 0;

   // Keys the stimulus has sent in insert requests, so lookups and repeat inserts find real entries.
   logic [31:0] known_keys [$];

   sht_req_if req_bus ();
   sht_rsp_if rsp_bus ();

   symbol_hash_table dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   sht_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_payload      (req_bus.payload),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_payload      (rsp_bus.payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .response_count   (response_count)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_bus.valid = 0;
      req_bus.payload = '0;
      rsp_bus.ready = 0;
   end

   // A watchdog: any hang in the handshakes ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one, and stretches of none at all.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The response side stalls on its own schedule, independent of the sender:
   // one ready cycle, then a gap of random length; while sink_stall_long is set, ready stays high.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 0;
         rsp_gap <= 0;
      end else if (sink_stall_long) begin
         rsp_bus.ready <= 1;
      end else if (rsp_gap != 0) begin
         rsp_bus.ready <= 0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_bus.ready <= 1;
         rsp_gap <= gap_length();
      end
   end

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // Drives one request beat and holds it until the block takes it. Valid stays
   // high into the next beat when there is no gap.
   task automatic send_beat(req_payload_type p);
      int gap;
      gap = gap_length();
      if (gap != 0) begin
         req_bus.valid <= 0;
         idle_cycles(gap);
      end
      req_bus.valid <= 1;
      req_bus.payload <= p;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      if (p.req_type == REQ_INSERT && p.key_hash != 0) known_keys.push_back(p.key_hash);
   endtask

   function automatic req_payload_type make_req(logic op, logic [31:0] key, logic [3:0] kind,
                                                logic [3:0] sel);
      req_payload_type p;
      p.req_type = op;
      p.key_hash = key;
      p.symbol_kind = kind;
      p.file_handle = $urandom();
      p.declaration_handle = $urandom();
      p.overload_select = sel;
      return p;
   endfunction

   // Waits until every expected beat has come back, then lets the block settle.
   task automatic drain();
      req_bus.valid <= 0;
      do @(posedge clock); while (pending_count != 0);
      idle_cycles(16);
   endtask

   task automatic write_kind_register(logic [3:0] value);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   // Picks a key: often one already in the table, sometimes a colliding one
   // (same home slot), rarely zero, otherwise fresh.
   function automatic logic [31:0] pick_key();
      int roll;
      logic [31:0] k;
      roll = $urandom_range(0, 99);
      if (roll < 3) return '0;
      if (roll < 50 && known_keys.size() != 0)
         return known_keys[$urandom_range(0, known_keys.size() - 1)];
      if (roll < 65 && known_keys.size() != 0) begin
         k = known_keys[$urandom_range(0, known_keys.size() - 1)];
         return k + (32'($urandom_range(1, 8)) << SLOT_W);
      end
      k = $urandom();
      return (k == 0) ? 32'd1 : k;
   endfunction

   task automatic random_phase(int count, logic [3:0] fn_kind);
      req_payload_type p;
      logic [3:0]      kind;
      repeat (count) begin
         kind = ($urandom_range(0, 1) == 1) ? fn_kind : 4'($urandom());
         p = make_req(1'($urandom_range(0, 1)), pick_key(), kind, 4'($urandom()));
         send_beat(p);
      end
   endtask

   initial begin
      req_payload_type p;
      logic [31:0]     fn_key;
      logic [3:0]      kinds [4];
      repeat (3) @(posedge clock);
      reset <= 0;
      // The block clears its key memory after reset; two beats queue meanwhile, the rest wait.

      // Directed part with the reset kind 0 as the function set kind.
      send_beat(make_req(REQ_INSERT, 32'd0, 4'd0, 4'd0));          // bad key, insert
      send_beat(make_req(REQ_LOOKUP, 32'd0, 4'd0, 4'd0));          // bad key, lookup
      send_beat(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 4'd3, 4'hF));  // not found
      send_beat(make_req(REQ_INSERT, 32'hFFFF_FFFF, 4'hF, 4'd0));  // plain insert
      send_beat(make_req(REQ_INSERT, 32'hFFFF_FFFF, 4'hF, 4'd0));  // plain duplicate
      send_beat(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 4'd0, 4'hF));  // plain lookup
      fn_key = 32'h0000_0400;                                      // home slot 0
      send_beat(make_req(REQ_INSERT, fn_key, 4'd0, 4'd0));
      repeat (16) send_beat(make_req(REQ_INSERT, fn_key, 4'd0, 4'd0)); // fill, then full
      send_beat(make_req(REQ_INSERT, fn_key, 4'd5, 4'd0));          // kind mismatch
      send_beat(make_req(REQ_LOOKUP, fn_key, 4'd0, 4'd15));         // last overload
      send_beat(make_req(REQ_INSERT, 32'h0000_0800, 4'd1, 4'd0));   // collides, probes on
      send_beat(make_req(REQ_LOOKUP, 32'h0000_0800, 4'd0, 4'd0));

      // The sender holds off here until the response queue is empty.
      drain();
      sink_stall_long = 1;
      random_phase(40, 4'd0);
      sink_stall_long = 0;

      // Random phases across several register settings, extremes included.
      kinds = '{4'hF, 4'd7, 4'd0, 4'd9};
      foreach (kinds[i]) begin
         write_kind_register(kinds[i]);
         random_phase(150, kinds[i]);
      end

      // Pack the table to the load limit, then keep inserting past it.
      write_kind_register(4'd3);
      while (scoreboard.occupancy < LOAD_LIMIT) begin
         p = make_req(REQ_INSERT, {22'($urandom_range(1, 65535)), 10'($urandom())},
                      4'd3, 4'd0);
         send_beat(p);
         drain();
      end
      random_phase(60, 4'd3);

      drain();
      scoreboard.report_leftovers();
      $display("sent %0d request beats, checked %0d response beats, %0d table entries",
               beats_sent, response_count, scoreboard.occupancy);
      $display("register settings 0, 15, 7, 9 and 3; load limit reached");
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
